// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/edf_pkg.sv =====
package edf_pkg;

	// parameter defaults
	localparam int WIDTH_DEF      = 256;
	localparam int HEIGHT_DEF     = 256;
	localparam int MAX_RADIUS_DEF = 3;
	localparam int TS_BITS_DEF    = 32;

	// field widths
	localparam int TS_IN_W    = 32;
	localparam int POS_W      = 8;
	localparam int DENS_W     = 3;
	localparam int THR_W      = 4;
	localparam int RAD_W      = 2;
	localparam int TW_W       = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// signed window coordinate and offset widths (covers 1024 pixels, radius 7)
	localparam int CRD_W = 12;
	localparam int OFS_W = 4;

	localparam int DENS_MAX = 7;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_WINDOW = 2'd2;

	// register reset values
	localparam logic [THR_W-1:0] THRESHOLD_RST   = 4'd2;
	localparam logic [RAD_W-1:0] RADIUS_RST      = 2'd1;
	localparam logic [TW_W-1:0]  TIME_WINDOW_RST = 32'd10000;

	typedef struct packed {
		logic [TS_IN_W-1:0] timestamp;
		logic [POS_W-1:0]   pos_x;
		logic [POS_W-1:0]   pos_y;
		logic               polarity;
	} edf_event_t;

	typedef struct packed {
		logic              keep;
		logic [DENS_W-1:0] density;
	} edf_result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} edf_state_t;

endpackage

// ===== rtl/edf_pixel_ram.sv =====
module edf_pixel_ram #(
	parameter int DEPTH  = edf_pkg::WIDTH_DEF * edf_pkg::HEIGHT_DEF,
	parameter int DATA_W = edf_pkg::TS_BITS_DEF + 2,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/event_density_denoise_filter.sv =====
// Event density denoise filter. Each event transaction (timestamp, pos_x, pos_y, polarity)
// is judged against a pixel memory that holds, per pixel, the time and polarity of the
// last event written there plus a valid flag. The square window of radius
// min(window_radius, MAX_RADIUS) around the event is walked column by column, one memory
// read per window cell; a cell supports the event when it is inside the sensor, valid,
// of the same polarity, and younger than time_window (age taken modulo 2^TS_BITS). The
// best column count, saturated at 7, is the density; keep = density >= support_threshold.
// Every event inside the sensor is then written into its own pixel, kept or not.
// The window walk is bound by the single read port of the pixel memory: one window cell
// is read per cycle in SCAN. Each cell then passes the read and compare pipeline (s1, s2);
// when the last cell leaves it, FINISH writes the event back into its pixel and loads the
// result into the output register, waiting there while a stalled result still holds the
// output. The next event is only taken in IDLE, after FINISH.
// One event is in work at a time; the next is accepted while the previous result still
// waits at the output.
// After reset the memory is swept empty, one pixel per cycle, over all WIDTH*HEIGHT pixels;
// evt_stall stays high meanwhile, configuration writes are taken.
// Configuration is always ready and must only be written while the block is idle.
module event_density_denoise_filter #(
	parameter int WIDTH      = edf_pkg::WIDTH_DEF,
	parameter int HEIGHT     = edf_pkg::HEIGHT_DEF,
	parameter int MAX_RADIUS = edf_pkg::MAX_RADIUS_DEF,
	parameter int TS_BITS    = edf_pkg::TS_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              evt_valid,
	output logic                              evt_stall,
	input  edf_pkg::edf_event_t               evt,
	output logic                              res_valid,
	input  logic                              res_stall,
	output edf_pkg::edf_result_t              res,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [edf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [edf_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int DEPTH = WIDTH * HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int ENT_W = TS_BITS + 2;          // {valid, polarity, time}
	localparam int CNT_W = $clog2(2 * MAX_RADIUS + 2);
	localparam int CMP_W = (TS_BITS > edf_pkg::TW_W) ? TS_BITS : edf_pkg::TW_W;

	localparam int OFS_W_L = edf_pkg::OFS_W;
	localparam int CRD_W_L = edf_pkg::CRD_W;

	// configuration registers
	logic [edf_pkg::THR_W-1:0] threshold_q;
	logic [edf_pkg::RAD_W-1:0] radius_q;
	logic [edf_pkg::TW_W-1:0]  time_window_q;

	// sequencer
	edf_pkg::edf_state_t state_q, state_d;
	logic                issue;
	logic                fin_fire;
	logic [AW-1:0]       clr_addr_q;

	// event in work and window walk
	edf_pkg::edf_event_t      ev_q;
	logic signed [OFS_W_L-1:0] rad_q, dx_q, dy_q;
	logic [OFS_W_L-1:0]        r_eff;
	logic                      last_cell, col_end;

	logic signed [CRD_W_L-1:0] cx, cy;
	logic [CRD_W_L-1:0]        cx_u, cy_u;
	logic                      cell_inb;
	logic [AW-1:0]             cell_addr;

	// read / compare pipeline
	logic               vld_s1, inb_s1, col_end_s1, last_s1;
	logic               vld_s2, sup_s2, col_end_s2, last_s2;
	logic [ENT_W-1:0]   rd_data;
	logic [TS_BITS-1:0] ev_ts, age;
	logic               sup;

	// column counting
	logic [CNT_W-1:0]          col_q, col_sum, density_q;
	logic [edf_pkg::DENS_W-1:0] dens_sat;

	// write port
	logic               ram_we;
	logic [AW-1:0]      ram_waddr, own_addr;
	logic [ENT_W-1:0]   ram_wdata;
	logic               own_inb;

	// output register
	logic                 res_valid_q;
	edf_pkg::edf_result_t res_q;

	logic evt_acc;

	assign evt_acc   = evt_valid && !evt_stall;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q   <= edf_pkg::THRESHOLD_RST;
			radius_q      <= edf_pkg::RADIUS_RST;
			time_window_q <= edf_pkg::TIME_WINDOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				edf_pkg::REG_THRESHOLD: begin
					threshold_q <= cfg_data[edf_pkg::THR_W-1:0];
				end
				edf_pkg::REG_RADIUS: begin
					radius_q <= cfg_data[edf_pkg::RAD_W-1:0];
				end
				edf_pkg::REG_TIME_WINDOW: begin
					time_window_q <= cfg_data[edf_pkg::TW_W-1:0];
				end
				default: begin
					// index past the register list: dropped
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= edf_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		issue     = 1'b0;
		fin_fire  = 1'b0;
		evt_stall = 1'b1;
		case (state_q)
			edf_pkg::ST_CLEAR: begin
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					state_d = edf_pkg::ST_IDLE;
				end
			end
			edf_pkg::ST_IDLE: begin
				evt_stall = 1'b0;
				if (evt_valid) begin
					state_d = edf_pkg::ST_SCAN;
				end
			end
			edf_pkg::ST_SCAN: begin
				issue = 1'b1;
				if (last_cell) begin
					state_d = edf_pkg::ST_DRAIN;
				end
			end
			edf_pkg::ST_DRAIN: begin
				// wait for the last cell to leave the compare pipeline
				if (vld_s2 && last_s2) begin
					state_d = edf_pkg::ST_FINISH;
				end
			end
			edf_pkg::ST_FINISH: begin
				// output slot free, or being emptied this cycle
				if (!res_valid_q || !res_stall) begin
					fin_fire = 1'b1;
					state_d  = edf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = edf_pkg::ST_IDLE;
			end
		endcase
	end

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (state_q == edf_pkg::ST_CLEAR) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// ---------------------------------------------------------------- window walk
	assign r_eff = (32'(radius_q) > 32'(MAX_RADIUS)) ? OFS_W_L'(MAX_RADIUS)
	                                                 : OFS_W_L'(radius_q);

	always_ff @(posedge clk) begin
		if (evt_acc) begin
			ev_q  <= evt;
			rad_q <= $signed(r_eff);
			dx_q  <= -$signed(r_eff);
			dy_q  <= -$signed(r_eff);
		end else if (issue) begin
			// column-major: dy runs fastest, dx steps at the column end
			if (col_end) begin
				dy_q <= -rad_q;
				dx_q <= dx_q + 1'b1;
			end else begin
				dy_q <= dy_q + 1'b1;
			end
		end
	end

	assign col_end   = (dy_q == rad_q);
	assign last_cell = col_end && (dx_q == rad_q);

	assign cx   = $signed(CRD_W_L'(ev_q.pos_x)) + CRD_W_L'(dx_q);
	assign cy   = $signed(CRD_W_L'(ev_q.pos_y)) + CRD_W_L'(dy_q);
	assign cx_u = cx;
	assign cy_u = cy;

	// cells off the sensor are read but never count
	assign cell_inb  = (cx >= 0) && (cx < $signed(CRD_W_L'(WIDTH))) &&
	                   (cy >= 0) && (cy < $signed(CRD_W_L'(HEIGHT)));
	assign cell_addr = AW'(32'(cy_u) * 32'(WIDTH) + 32'(cx_u));

	// ---------------------------------------------------------------- pixel memory
	edf_pixel_ram #(
		.DEPTH  (DEPTH),
		.DATA_W (ENT_W),
		.ADDR_W (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cell_addr),
		.rdata (rd_data)
	);

	assign own_inb  = (32'(ev_q.pos_x) < 32'(WIDTH)) && (32'(ev_q.pos_y) < 32'(HEIGHT));
	assign own_addr = AW'(32'(ev_q.pos_y) * 32'(WIDTH) + 32'(ev_q.pos_x));
	assign ev_ts    = TS_BITS'(ev_q.timestamp);

	// write-back happens in FINISH, strictly after the last read of this event and
	// before the first read of the next one, so no forwarding is needed
	always_comb begin
		if (state_q == edf_pkg::ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = fin_fire && own_inb;
			ram_waddr = own_addr;
			ram_wdata = {1'b1, ev_q.polarity, ev_ts};
		end
	end

	// ---------------------------------------------------------------- compare pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		inb_s1     <= cell_inb;
		col_end_s1 <= col_end;
		last_s1    <= last_cell;
		sup_s2     <= sup;
		col_end_s2 <= col_end_s1;
		last_s2    <= last_s1;
	end

	// age wraps modulo 2^TS_BITS
	assign age = ev_ts - rd_data[TS_BITS-1:0];
	assign sup = vld_s1 && inb_s1 && rd_data[TS_BITS+1] &&
	             (rd_data[TS_BITS] == ev_q.polarity) &&
	             (CMP_W'(age) < CMP_W'(time_window_q));

	// ---------------------------------------------------------------- column max
	assign col_sum = col_q + CNT_W'(sup_s2);

	always_ff @(posedge clk) begin
		if (evt_acc) begin
			col_q     <= '0;
			density_q <= '0;
		end else if (vld_s2) begin
			if (col_end_s2) begin
				col_q <= '0;
				if (col_sum > density_q) begin
					density_q <= col_sum;
				end
			end else begin
				col_q <= col_sum;
			end
		end
	end

	assign dens_sat = (32'(density_q) > 32'(edf_pkg::DENS_MAX))
	                ? edf_pkg::DENS_W'(edf_pkg::DENS_MAX)
	                : edf_pkg::DENS_W'(density_q);

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fin_fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			res_q.keep    <= ({1'b0, dens_sat} >= threshold_q);
			res_q.density <= dens_sat;
		end
	end

endmodule

// ===== rtl/edf_checker.sv =====
`include "assert_macros.svh"

module edf_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           evt_valid,
	input logic                           evt_stall,
	input edf_pkg::edf_event_t            evt,
	input logic                           res_valid,
	input logic                           res_stall,
	input edf_pkg::edf_result_t           res,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [edf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [edf_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [edf_pkg::THR_W-1:0] thr_q;
	logic [edf_pkg::RAD_W-1:0] rad_q;
	logic [1:0]                pend_q;
	logic                      evt_acc, res_acc;
	logic [edf_pkg::THR_W-1:0] win_h;

	assign evt_acc = evt_valid && !evt_stall;
	assign res_acc = res_valid && !res_stall;
	assign win_h   = {1'b0, rad_q, 1'b1};

	// shadow of the registers that bound the results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= edf_pkg::THRESHOLD_RST;
			rad_q <= edf_pkg::RADIUS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				edf_pkg::REG_THRESHOLD: begin
					thr_q <= cfg_data[edf_pkg::THR_W-1:0];
				end
				edf_pkg::REG_RADIUS: begin
					rad_q <= cfg_data[edf_pkg::RAD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// events accepted whose result is not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (evt_acc && !res_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (res_acc && !evt_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	`EDF_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res), "stalled result transaction changed")
	`EDF_ASSERT_IMP(a_no_phantom, clk, arst_n, res_valid, pend_q != 2'd0, "result without an accepted event")
	`EDF_ASSERT_IMP(a_one_in_work, clk, arst_n, evt_acc, pend_q <= 2'd1, "event accepted while another is still in work")
	`EDF_ASSERT_IMP(a_keep_rule, clk, arst_n, res_valid, res.keep == ({1'b0, res.density} >= thr_q), "keep disagrees with density and threshold")
	`EDF_ASSERT_IMP(a_dens_bound, clk, arst_n, res_valid, {1'b0, res.density} <= win_h, "density larger than a window column")

endmodule

bind event_density_denoise_filter edf_checker u_edf_checker (.*);
